/* design/ptc_pkg.sv */
// shared types, constants and helpers for the pressure/temperature compensation block
// no dependencies
package ptc_pkg;

  localparam int NumRegs      = 6;
  localparam int AddrW        = 5;
  localparam int DataW        = 32;
  localparam int FifoDepthDef = 8;
  localparam int MulLat       = 2;
  localparam int DivBits      = 64;
  localparam int FrontStages  = 4;

  typedef enum logic [2:0] {
    RegT1T2 = 3'd0,
    RegT3P1 = 3'd1,
    RegP2P3 = 3'd2,
    RegP4P5 = 3'd3,
    RegP6P7 = 3'd4,
    RegP8P9 = 3'd5
  } reg_idx_e;

  typedef logic [NumRegs-1:0][DataW-1:0] calib_t;

  // word handed from the temperature front to the pressure back
  typedef struct packed {
    logic [31:0] t_fine;
    logic [31:0] temp;
    logic [19:0] adc_p;
  } tword_t;

  // per-item control traveling alongside the pressure datapath
  typedef struct packed {
    logic        vld;
    logic [31:0] temp;
    logic [19:0] adc_p;
    logic        fault;
  } meta_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] zx16(input logic [15:0] v);
    zx16 = {48'b0, v};
  endfunction

endpackage

/* design/ptc_mul64.sv */
// two-stage 64x64 multiplier giving the low 64 bits of the product
// built from three 32x32 partial products; no package dependency
module ptc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_d, lh_d, hl_d;
  logic [63:0] ll_q, p_q;
  logic [31:0] lh_q, hl_q;
  logic [31:0] mid;

  assign ll_d = a_i[31:0] * b_i[31:0];
  assign lh_d = a_i[31:0] * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];
  assign mid  = lh_q + hl_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d[31:0];
      hl_q <= hl_d[31:0];
      p_q  <= ll_q + {mid, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

/* design/ptc_dly.sv */
// enabled delay line of fixed depth
// no package dependency beyond default values
module ptc_dly #(
  parameter int Width = 64,
  parameter int Depth = ptc_pkg::MulLat
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

/* design/ptc_div.sv */
// pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero
// uses ptc_pkg for the side word that travels with each item
module ptc_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [63:0]    n_i,
  input  logic [63:0]    d_i,
  input  ptc_pkg::meta_t sb_i,
  output logic [63:0]    q_o,
  output ptc_pkg::meta_t sb_o
);
  import ptc_pkg::*;

  logic [63:0] r_q   [DivBits+1];
  logic [63:0] nq_q  [DivBits+1];
  logic [63:0] dv_q  [DivBits+1];
  logic        neg_q [DivBits+1];
  meta_t       sb_q  [DivBits+1];
  logic [63:0] q_q;
  meta_t       sbo_q;
  logic [63:0] an, ad;

  assign an = n_i[63] ? (64'd0 - n_i) : n_i;
  assign ad = d_i[63] ? (64'd0 - d_i) : d_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= '0;
      nq_q[0]  <= an;
      dv_q[0]  <= ad;
      neg_q[0] <= n_i[63] ^ d_i[63];
      q_q      <= neg_q[DivBits] ? (64'd0 - nq_q[DivBits]) : nq_q[DivBits];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q[0] <= '0;
      sbo_q   <= '0;
    end else if (en_i) begin
      sb_q[0] <= sb_i;
      sbo_q   <= sb_q[DivBits];
    end
  end

  for (genvar k = 0; k < DivBits; k++) begin : g_stage
    logic [64:0] rt, rs;
    logic        ge;
    // shift next dividend bit into the partial remainder
    assign rt = {r_q[k], nq_q[k][63]};
    assign rs = rt - {1'b0, dv_q[k]};
    assign ge = rt >= {1'b0, dv_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= ge ? rs[63:0] : rt[63:0];
        nq_q[k+1]  <= {nq_q[k][62:0], ge};
        dv_q[k+1]  <= dv_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_q[k+1] <= '0;
      end else if (en_i) begin
        sb_q[k+1] <= sb_q[k];
      end
    end
  end

  assign q_o  = q_q;
  assign sb_o = sbo_q;

endmodule

/* design/ptc_fifo.sv */
// small queue between the temperature front and the pressure back
// uses ptc_pkg for the queued word type
module ptc_fifo #(
  parameter int Depth = ptc_pkg::FifoDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  ptc_pkg::tword_t              wdata_i,
  input  logic                         pop_i,
  output ptc_pkg::tword_t              rdata_o,
  output logic                         empty_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);
  import ptc_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth+1);

  tword_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              full;

  assign full    = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full || pop_i)) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");

endmodule

/* design/ptc_front.sv */
// temperature front: four stages, 32-bit wrapping, yields t_fine and centidegrees
// uses ptc_pkg for calibration and word types
module ptc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptc_pkg::calib_t     calib_i,
  input  logic                vld_i,
  input  logic [19:0]         adc_t_i,
  input  logic [19:0]         adc_p_i,
  output logic                vld_o,
  output ptc_pkg::tword_t     word_o,
  output logic [2:0]          busy_o
);
  import ptc_pkg::*;

  logic [FrontStages-1:0] v_q;
  logic [31:0] t1, t2, t3;
  logic [31:0] x1_q, d_q, m1_q, dd_q, a_q, m3_q;
  logic [31:0] x1_d, d_d, tf, tf5;
  logic [19:0] p1_q, p2_q, p3_q;
  tword_t      w_q;

  assign t1   = {16'b0, calib_i[RegT1T2][15:0]};
  assign t2   = {{16{calib_i[RegT1T2][31]}}, calib_i[RegT1T2][31:16]};
  assign t3   = {{16{calib_i[RegT3P1][15]}}, calib_i[RegT3P1][15:0]};
  assign x1_d = {15'b0, adc_t_i[19:3]} - (t1 << 1);
  assign d_d  = {16'b0, adc_t_i[19:4]} - t1;
  assign tf   = a_q + 32'($signed(m3_q) >>> 14);
  assign tf5  = (tf << 2) + tf + 32'd128;

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d;
    d_q  <= d_d;
    p1_q <= adc_p_i;
    m1_q <= x1_q * t2;
    dd_q <= d_q * d_q;
    p2_q <= p1_q;
    a_q  <= 32'($signed(m1_q) >>> 11);
    m3_q <= 32'($signed(dd_q) >>> 12) * t3;
    p3_q <= p2_q;
    w_q.t_fine <= tf;
    w_q.temp   <= 32'($signed(tf5) >>> 8);
    w_q.adc_p  <= p3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FrontStages-2:0], vld_i};
    end
  end

  assign vld_o  = v_q[FrontStages-1];
  assign word_o = w_q;
  assign busy_o = 3'($countones(v_q));

endmodule

/* design/ptc_back.sv */
// pressure back: 64-bit wrapping datapath with pipelined multipliers and divider
// depends on ptc_pkg, ptc_mul64, ptc_dly, ptc_div
module ptc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ptc_pkg::calib_t calib_i,
  input  logic            empty_i,
  input  ptc_pkg::tword_t word_i,
  output logic            pop_o,
  output logic            out_vld_o,
  input  logic            out_stall_i,
  output logic [31:0]     temp_o,
  output logic [31:0]     press_o,
  output logic            fault_o
);
  import ptc_pkg::*;

  localparam int MW = $bits(meta_t);

  logic        en;
  logic [63:0] p2, p3, p4, p5, p6, p7, p8, p9, p1;
  meta_t       m0_q, m2, m4, m5_q, m7, m8_q, m10, mdiv, m76, m77_q, m79, m81, m82_q;
  logic [63:0] v1_q, sq, v1p5, v1p2, sqp6, sqp3, v1p5_d, v1p2_d;
  logic [63:0] v2_q, x_q, y, v2_7, dv_q, pd_q, nw, dv10, q76;
  logic [63:0] q_q, q13_q, a9, p8q, q13_79, q_79, b, p8s_81, q_81, s_q, res;
  logic [20:0] p0;
  logic        out_vld_q, fault_q;
  logic [31:0] temp_q, press_q;

  assign en    = !(out_vld_q && out_stall_i);
  assign pop_o = en && !empty_i;

  assign p1 = zx16(calib_i[RegT3P1][31:16]);
  assign p2 = sx16(calib_i[RegP2P3][15:0]);
  assign p3 = sx16(calib_i[RegP2P3][31:16]);
  assign p4 = sx16(calib_i[RegP4P5][15:0]);
  assign p5 = sx16(calib_i[RegP4P5][31:16]);
  assign p6 = sx16(calib_i[RegP6P7][15:0]);
  assign p7 = sx16(calib_i[RegP6P7][31:16]);
  assign p8 = sx16(calib_i[RegP8P9][15:0]);
  assign p9 = sx16(calib_i[RegP8P9][31:16]);

  // entry: widen t_fine and take off the offset
  always_ff @(posedge clk_i) begin
    if (en) v1_q <= {{32{word_i.t_fine[31]}}, word_i.t_fine} - 64'd128000;
  end

  ptc_mul64 u_sq   (.clk_i, .en_i(en), .a_i(v1_q), .b_i(v1_q), .p_o(sq));
  ptc_mul64 u_v1p5 (.clk_i, .en_i(en), .a_i(v1_q), .b_i(p5),   .p_o(v1p5));
  ptc_mul64 u_v1p2 (.clk_i, .en_i(en), .a_i(v1_q), .b_i(p2),   .p_o(v1p2));
  ptc_dly #(.Width(MW)) u_m2 (.clk_i, .rst_ni, .en_i(en), .d_i(m0_q), .q_o(m2));

  ptc_mul64 u_sqp6 (.clk_i, .en_i(en), .a_i(sq), .b_i(p6), .p_o(sqp6));
  ptc_mul64 u_sqp3 (.clk_i, .en_i(en), .a_i(sq), .b_i(p3), .p_o(sqp3));
  ptc_dly #(.Width(128)) u_lin (.clk_i, .rst_ni, .en_i(en), .d_i({v1p5, v1p2}),
                                .q_o({v1p5_d, v1p2_d}));
  ptc_dly #(.Width(MW)) u_m4 (.clk_i, .rst_ni, .en_i(en), .d_i(m2), .q_o(m4));

  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_q <= sqp6 + (v1p5_d << 17) + (p4 << 35);
      x_q  <= 64'h0000_8000_0000_0000 + 64'($signed(sqp3) >>> 8) + (v1p2_d << 12);
    end
  end

  ptc_mul64 u_y (.clk_i, .en_i(en), .a_i(x_q), .b_i(p1), .p_o(y));
  ptc_dly #(.Width(64)) u_v2 (.clk_i, .rst_ni, .en_i(en), .d_i(v2_q), .q_o(v2_7));
  ptc_dly #(.Width(MW)) u_m7 (.clk_i, .rst_ni, .en_i(en), .d_i(m5_q), .q_o(m7));

  assign p0 = 21'h100000 - {1'b0, m7.adc_p};

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q <= 64'($signed(y) >>> 33);
      pd_q <= ({43'b0, p0} << 31) - v2_7;
    end
  end

  ptc_mul64 u_n (.clk_i, .en_i(en), .a_i(pd_q), .b_i(64'd3125), .p_o(nw));
  ptc_dly #(.Width(64)) u_dv (.clk_i, .rst_ni, .en_i(en), .d_i(dv_q), .q_o(dv10));
  ptc_dly #(.Width(MW)) u_m10 (.clk_i, .rst_ni, .en_i(en), .d_i(m8_q), .q_o(m10));

  // zero divisor flags the item; the divider output is then ignored
  always_comb begin
    mdiv       = m10;
    mdiv.fault = dv10 == 64'd0;
  end

  ptc_div u_div (.clk_i, .rst_ni, .en_i(en), .n_i(nw), .d_i(dv10), .sb_i(mdiv),
                 .q_o(q76), .sb_o(m76));

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q   <= q76;
      q13_q <= 64'($signed(q76) >>> 13);
    end
  end

  ptc_mul64 u_a9  (.clk_i, .en_i(en), .a_i(p9), .b_i(q13_q), .p_o(a9));
  ptc_mul64 u_p8q (.clk_i, .en_i(en), .a_i(p8), .b_i(q_q),   .p_o(p8q));
  ptc_dly #(.Width(128)) u_q79 (.clk_i, .rst_ni, .en_i(en), .d_i({q13_q, q_q}),
                                .q_o({q13_79, q_79}));
  ptc_dly #(.Width(MW)) u_m79 (.clk_i, .rst_ni, .en_i(en), .d_i(m77_q), .q_o(m79));

  ptc_mul64 u_b (.clk_i, .en_i(en), .a_i(a9), .b_i(q13_79), .p_o(b));
  ptc_dly #(.Width(128)) u_q81 (.clk_i, .rst_ni, .en_i(en),
                                .d_i({64'($signed(p8q) >>> 19), q_79}),
                                .q_o({p8s_81, q_81}));
  ptc_dly #(.Width(MW)) u_m81 (.clk_i, .rst_ni, .en_i(en), .d_i(m79), .q_o(m81));

  always_ff @(posedge clk_i) begin
    if (en) s_q <= q_81 + 64'($signed(b) >>> 25) + p8s_81;
  end

  assign res = 64'($signed(s_q) >>> 8) + (p7 << 4);

  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q  <= m82_q.temp;
      press_q <= m82_q.fault ? 32'd0 : res[31:0];
      fault_q <= m82_q.fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m0_q      <= '0;
      m5_q      <= '0;
      m8_q      <= '0;
      m77_q     <= '0;
      m82_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m0_q.vld   <= pop_o;
      m0_q.temp  <= word_i.temp;
      m0_q.adc_p <= word_i.adc_p;
      m0_q.fault <= 1'b0;
      m5_q       <= m4;
      m8_q       <= m7;
      m77_q      <= m76;
      m82_q      <= m81;
      out_vld_q  <= m82_q.vld;
    end
  end

  assign out_vld_o = out_vld_q;
  assign temp_o    = temp_q;
  assign press_o   = press_q;
  assign fault_o   = fault_q;

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && fault_q |-> press_q == 32'd0) else $error("fault word with pressure");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && !pop_o || !out_stall_i)
    else $error("back advanced while output stalled");

endmodule

/* design/pressure_temp_compensation.sv */
// top level: calibration registers, temperature front, queue, pressure back
// depends on ptc_pkg, ptc_front, ptc_fifo, ptc_back
//
//  channel  direction  handshake              payload
//  in       to block   in_valid_i/in_stall_o  raw_temperature_i, raw_pressure_i
//  out      from block out_valid_o/out_stall_i temperature_centi_o, pressure_q24_8_o,
//                                              calib_fault_o
//  cfg      to block   psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// one word accepted per cycle while in_stall_o is low; the pipeline depth comes mostly
// from the 64-stage divider and the pipelined multipliers of the pressure path
// reset clears valid bits, queue pointers and calibration registers (all zero)
// out_stall_i freezes the back while out_valid_o is high; the front keeps running and
// in_stall_o rises once the queue plus words still in the front would fill the queue
module pressure_temp_compensation #(
  parameter int FifoDepth = ptc_pkg::FifoDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [19:0]               raw_temperature_i,
  input  logic [19:0]               raw_pressure_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [31:0]        temperature_centi_o,
  output logic [31:0]               pressure_q24_8_o,
  output logic                      calib_fault_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ptc_pkg::AddrW-1:0] paddr,
  input  logic [ptc_pkg::DataW-1:0] pwdata,
  output logic [ptc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import ptc_pkg::*;

  localparam int CntW = $clog2(FifoDepth+1);
  localparam int OccW = (CntW > 2) ? CntW + 1 : 4;

  calib_t          calib_q;
  logic            f_vld, pop, empty;
  tword_t          f_word, q_word;
  logic [2:0]      busy;
  logic [CntW-1:0] cnt;
  logic [OccW-1:0] occ;
  logic [31:0]     temp;
  reg_idx_e        idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_q <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        RegT1T2: calib_q[RegT1T2] <= pwdata;
        RegT3P1: calib_q[RegT3P1] <= pwdata;
        RegP2P3: calib_q[RegP2P3] <= pwdata;
        RegP4P5: calib_q[RegP4P5] <= pwdata;
        RegP6P7: calib_q[RegP6P7] <= pwdata;
        RegP8P9: calib_q[RegP8P9] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegT1T2: prdata = calib_q[RegT1T2];
      RegT3P1: prdata = calib_q[RegT3P1];
      RegP2P3: prdata = calib_q[RegP2P3];
      RegP4P5: prdata = calib_q[RegP4P5];
      RegP6P7: prdata = calib_q[RegP6P7];
      RegP8P9: prdata = calib_q[RegP8P9];
      default: prdata = '0;
    endcase
  end

  // reserve queue room for every word still in the front
  assign occ        = OccW'(cnt) + OccW'(busy);
  assign in_stall_o = occ >= OccW'(FifoDepth);

  ptc_front u_front (
    .clk_i, .rst_ni, .calib_i(calib_q),
    .vld_i(in_valid_i && !in_stall_o),
    .adc_t_i(raw_temperature_i), .adc_p_i(raw_pressure_i),
    .vld_o(f_vld), .word_o(f_word), .busy_o(busy)
  );

  ptc_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(f_vld), .wdata_i(f_word), .pop_i(pop),
    .rdata_o(q_word), .empty_o(empty), .count_o(cnt)
  );

  ptc_back u_back (
    .clk_i, .rst_ni, .calib_i(calib_q), .empty_i(empty), .word_i(q_word), .pop_o(pop),
    .out_vld_o(out_valid_o), .out_stall_i, .temp_o(temp),
    .press_o(pressure_q24_8_o), .fault_o(calib_fault_o)
  );

  assign temperature_centi_o = signed'(temp);

  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OccW'(FifoDepth)) else $error("queue reservation exceeded");

endmodule

/* tb/sv/pressure_temp_compensation_tb.sv */
// testbench for pressure_temp_compensation: drives raw reading pairs under random idling,
// predicts compensated temperature and pressure and checks every result word
// depends on ptc_pkg and the pressure_temp_compensation rtl
module pressure_temp_compensation_tb;
  import ptc_pkg::*;

  typedef struct {
    logic [31:0] temp;
    logic [31:0] press;
    logic        fault;
  } comp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [19:0] raw_t = '0;
  logic [19:0] raw_p = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] temp_out;
  logic [31:0] press_out;
  logic fault_out;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  logic [31:0] calib [NumRegs];
  comp_t expected_q[$];
  int errors = 0;
  int idle_cnt = 0;
  bit done = 1'b0;

  pressure_temp_compensation dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .raw_temperature_i(raw_t), .raw_pressure_i(raw_p),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .temperature_centi_o(temp_out), .pressure_q24_8_o(press_out),
    .calib_fault_o(fault_out),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] s16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic comp_t compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
    logic signed [31:0] t1, t2, t3, a, d, b, tf, tc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, n;
    logic [63:0] an, ad, q;
    comp_t r;
    t1 = {16'b0, calib[RegT1T2][15:0]};
    t2 = 32'(s16(calib[RegT1T2][31:16]));
    t3 = 32'(s16(calib[RegT3P1][15:0]));
    p1 = {48'b0, calib[RegT3P1][31:16]};
    p2 = s16(calib[RegP2P3][15:0]);
    p3 = s16(calib[RegP2P3][31:16]);
    p4 = s16(calib[RegP4P5][15:0]);
    p5 = s16(calib[RegP4P5][31:16]);
    p6 = s16(calib[RegP6P7][15:0]);
    p7 = s16(calib[RegP6P7][31:16]);
    p8 = s16(calib[RegP8P9][15:0]);
    p9 = s16(calib[RegP8P9][31:16]);
    a = (($signed({15'b0, adc_t[19:3]}) - (t1 <<< 1)) * t2) >>> 11;
    d = $signed({16'b0, adc_t[19:4]}) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    tf = a + b;
    tc = (tf * 5 + 128) >>> 8;
    r.temp = tc;
    v1 = 64'(tf) - 128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      r.press = '0;
      r.fault = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'b0, adc_p});
      n = ((p <<< 31) - v2) * 3125;
      // truncating divide done on magnitudes so overflow wraps
      an = n[63] ? -n : n;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      p = (n[63] != v1[63]) ? -q : q;
      v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      r.press = p[31:0];
      r.fault = 1'b0;
    end
    return r;
  endfunction

  // idle rates in percent
  int send_idle = 0;
  int recv_idle = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_idle);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected word: temp %h press %h fault %b", $time,
                   temp_out, press_out, fault_out);
          errors++;
        end else begin
          comp_t e;
          e = expected_q.pop_front();
          if (temp_out !== e.temp || press_out !== e.press || fault_out !== e.fault) begin
            $display("%0t mismatch: expected temp %h press %h fault %b, got %h %h %b",
                     $time, e.temp, e.press, e.fault, temp_out, press_out, fault_out);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || done)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("[pressure_temp_compensation] ERROR");
      $finish;
    end
  end

  // valid stays high after the accepting edge; the next send or drain decides it
  task automatic send_reading(input logic [19:0] t, input logic [19:0] pr);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_t <= t;
    raw_p <= pr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(compensate(t, pr));
  endtask

  task automatic write_calib(input reg_idx_e idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    calib[idx] = val;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic load_calib(input logic [31:0] v0, v1, v2, v3, v4, v5);
    drain();
    write_calib(RegT1T2, v0);
    write_calib(RegT3P1, v1);
    write_calib(RegP2P3, v2);
    write_calib(RegP4P5, v3);
    write_calib(RegP6P7, v4);
    write_calib(RegP8P9, v5);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // datasheet-like coefficients
  task automatic load_typical;
    load_calib({16'd26435, 16'd27504}, {16'd36477, -16'sd1000},
               {16'd3024, -16'sd10685}, {-16'sd7, 16'd2855},
               {16'd15500, 16'd140}, {16'd6000, -16'sd14600});
  endtask

  task automatic test_zero_calib;
    // all-zero p1 gives the zero divisor fault
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'h80000, 20'h7ffff);
  endtask

  task automatic test_directed;
    logic [19:0] pts [6] = '{20'h0, 20'hfffff, 20'h80000, 20'h7ffff, 20'h81a3c, 20'h65f00};
    load_typical();
    foreach (pts[i]) send_reading(pts[i], pts[5 - i]);
    send_reading(20'd519888, 20'd415148);
    // extreme coefficients, then all ones
    load_calib('1, 32'h7fff8000, 32'h80007fff, 32'h7fff7fff, 32'h80008000, 32'h7fff8000);
    foreach (pts[i]) send_reading(pts[i], pts[i]);
    load_calib('1, '1, '1, '1, '1, '1);
    foreach (pts[i]) send_reading(pts[i], pts[(i + 2) % 6]);
  endtask

  task automatic test_random(input int n, input bit typical);
    for (int i = 0; i < n; i++) begin
      if (typical)
        send_reading(20'($urandom_range(350000, 650000)), 20'($urandom_range(250000, 500000)));
      else
        send_reading(20'($urandom), 20'($urandom));
    end
  endtask

  task automatic test_random_calib(input int n);
    for (int k = 0; k < n; k++) begin
      load_calib($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      test_random(40, 1'b0);
    end
  endtask

  initial begin
    foreach (calib[i]) calib[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_calib();
    test_directed();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 9 : (ph == 1) ? 87 : 0;
      recv_idle = (ph == 0) ? 87 : (ph == 1) ? 9 : 0;
      load_typical();
      test_random(250, 1'b1);
      test_random_calib(4);
    end
    send_idle = 0;
    recv_idle = 0;
    drain();
    done = 1'b1;
    if (errors == 0)
      $display("[pressure_temp_compensation] OK");
    else
      $display("[pressure_temp_compensation] ERROR");
    $finish;
  end

endmodule

/* sim.f */
design/ptc_pkg.sv
design/ptc_mul64.sv
design/ptc_dly.sv
design/ptc_div.sv
design/ptc_fifo.sv
design/ptc_front.sv
design/ptc_back.sv
design/pressure_temp_compensation.sv
tb/sv/pressure_temp_compensation_tb.sv
